/* hdl/bsg_pkg.sv */
// Shared types and constants for the BMP stream grayscale converter.
// Depends on nothing; imported by bmp_stream_grayscale_core.
`default_nettype none

package bsg_pkg;

   // 24-bit pixels only: blue, green, red bytes.
   localparam int BitsPerPixel  = 24;
   localparam int BytesPerPixel = BitsPerPixel / 8;

   localparam int PositionBits  = 32;

   localparam int CsrDataBits   = 32;
   localparam int CsrAddrBits   = 5;

   // Result queue between the conversion stage and the output port.
   localparam int QueueDepth    = 4;
   localparam int QueuePtrBits  = $clog2(QueueDepth);
   localparam int QueueCntBits  = $clog2(QueueDepth + 1);

   localparam logic [31:0] HeaderLenReset   = 32'd54;
   localparam logic [15:0] ImageWidthReset  = 16'd1;
   localparam logic [15:0] ImageHeightReset = 16'd1;
   localparam logic [31:0] TotalLenReset    = 32'd0;
   localparam logic [8:0]  CoefRedReset     = 9'd77;
   localparam logic [8:0]  CoefGreenReset   = 9'd150;
   localparam logic [8:0]  CoefBlueReset    = 9'd29;

   localparam logic [7:0]  ByteMax          = 8'd255;

   // Register map, one 32-bit word per register.
   typedef enum logic [2:0] {
      REG_HEADER_LEN   = 3'd0,
      REG_IMAGE_WIDTH  = 3'd1,
      REG_IMAGE_HEIGHT = 3'd2,
      REG_TOTAL_LEN    = 3'd3,
      REG_COEF_RED     = 3'd4,
      REG_COEF_GREEN   = 3'd5,
      REG_COEF_BLUE    = 3'd6
   } reg_index_type;

   // Channel expected next inside a pixel.
   typedef enum logic [1:0] {
      PHASE_BLUE  = 2'd0,
      PHASE_GREEN = 2'd1,
      PHASE_RED   = 2'd2,
      PHASE_SPARE = 2'd3
   } phase_type;

   // Number of output bytes one input byte causes (zero is never queued).
   typedef enum logic [1:0] {
      EMIT_ONE   = 2'd1,
      EMIT_THREE = 2'd3
   } emit_count_type;

   // Work handed from the accept stage to the conversion stage.
   typedef struct packed {
      logic           is_pixel;
      emit_count_type count;
      logic [7:0]     data_byte;
      logic [7:0]     green;
      logic [7:0]     blue;
   } stage_type;

   // One queued result run: a byte value repeated count times.
   typedef struct packed {
      emit_count_type count;
      logic [7:0]     value;
   } run_type;

endpackage

`default_nettype wire

/* hdl/bmp_stream_grayscale_core.sv */
// Top level of the BMP stream grayscale converter: register port, stream
// parsing, luminosity conversion and the output run queue.
// Depends on bsg_pkg.
`default_nettype none

// Converts a 24-bit BMP file, streamed one byte per transaction, to gray.
// Header bytes (below header_len) pass through; each blue, green, red pixel
// becomes three copies of a gray byte built from Q1.8 weights, pure white
// stays white, row padding passes through and bytes after the pixel array
// pass through up to total_len, later ones are dropped. tuser high marks the
// first byte of a new file and clears the stream counters. Each input byte
// passes through the accept and conversion stages, so a byte can be taken
// every cycle while the run queue has room; a red byte yields three output
// transactions (tlast on the third), header and padding bytes yield one with
// tlast, blue and green bytes yield none. The four-entry run queue after the
// conversion stage sets how far input may run ahead of a stalled output. The
// user must see registers written only while the stream is idle; unchecked.
module bmp_stream_grayscale_core
   import bsg_pkg::*;
#(
   parameter int POSITION_BITS = PositionBits
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] in_byte
   input  wire logic                   req_tuser,   // [0] file_start

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] out_byte
   output logic                        rsp_tlast,

   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CsrAddrBits-1:0] csr_paddr,
   input  wire logic [CsrDataBits-1:0] csr_pwdata,
   output logic      [CsrDataBits-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

   // Configuration registers.
   logic [31:0] header_len_ff;
   logic [15:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [31:0] total_len_ff;
   logic [8:0]  coef_red_ff;
   logic [8:0]  coef_green_ff;
   logic [8:0]  coef_blue_ff;
   logic [31:0] pixel_total_ff;
   logic [31:0] pixel_total_in;

   logic          csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CsrAddrBits-1:2]);

   // The pixel count follows every width or height write at the same edge.
   always_comb begin
      pixel_total_in = pixel_total_ff;
      if (csr_write && csr_index == REG_IMAGE_WIDTH) begin
         pixel_total_in = csr_pwdata[15:0] * image_height_ff;
      end else if (csr_write && csr_index == REG_IMAGE_HEIGHT) begin
         pixel_total_in = image_width_ff * csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_len_ff   <= HeaderLenReset;
         image_width_ff  <= ImageWidthReset;
         image_height_ff <= ImageHeightReset;
         total_len_ff    <= TotalLenReset;
         coef_red_ff     <= CoefRedReset;
         coef_green_ff   <= CoefGreenReset;
         coef_blue_ff    <= CoefBlueReset;
         pixel_total_ff  <= 32'(ImageWidthReset * ImageHeightReset);
      end else begin
         pixel_total_ff <= pixel_total_in;
         if (csr_write) begin
            case (csr_index)
               REG_HEADER_LEN:   header_len_ff   <= csr_pwdata;
               REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[15:0];
               REG_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[15:0];
               REG_TOTAL_LEN:    total_len_ff    <= csr_pwdata;
               REG_COEF_RED:     coef_red_ff     <= csr_pwdata[8:0];
               REG_COEF_GREEN:   coef_green_ff   <= csr_pwdata[8:0];
               REG_COEF_BLUE:    coef_blue_ff    <= csr_pwdata[8:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (csr_index)
         REG_HEADER_LEN:   csr_prdata = header_len_ff;
         REG_IMAGE_WIDTH:  csr_prdata = {16'd0, image_width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {16'd0, image_height_ff};
         REG_TOTAL_LEN:    csr_prdata = total_len_ff;
         REG_COEF_RED:     csr_prdata = {23'd0, coef_red_ff};
         REG_COEF_GREEN:   csr_prdata = {23'd0, coef_green_ff};
         REG_COEF_BLUE:    csr_prdata = {23'd0, coef_blue_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Stream state.
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [31:0]              pixels_done_ff, pixels_done_in;
   logic [15:0]              column_ff, column_in;
   logic [1:0]               pad_left_ff, pad_left_in;
   phase_type                phase_ff, phase_in;
   logic [7:0]               held_blue_ff, held_blue_in;
   logic [7:0]               held_green_ff, held_green_in;

   logic      stage_valid_ff, stage_valid_in;
   stage_type stage_ff, stage_in;

   logic [QueueCntBits-1:0] queue_count_ff;
   logic                    req_fire;

   // Room is counted for the item already in the conversion stage.
   assign req_tready = ({1'b0, queue_count_ff} + (QueueCntBits+1)'(stage_valid_ff))
                       < (QueueCntBits+1)'(QueueDepth);
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      logic [POSITION_BITS-1:0] pos;
      logic [31:0]              done;
      logic [31:0]              done_next;
      logic [15:0]              column;
      logic [15:0]              column_next;
      logic [1:0]               pad;
      phase_type                phase;
      logic [7:0]               blue;
      logic [7:0]               green;

      pos    = req_tuser ? '0 : position_ff;
      done   = req_tuser ? '0 : pixels_done_ff;
      column = req_tuser ? '0 : column_ff;
      pad    = req_tuser ? '0 : pad_left_ff;
      phase  = req_tuser ? PHASE_BLUE : phase_ff;
      blue   = req_tuser ? '0 : held_blue_ff;
      green  = req_tuser ? '0 : held_green_ff;

      done_next   = done + 32'd1;
      column_next = column + 16'd1;

      position_in    = (pos < PosMax) ? pos + 1'b1 : pos;
      pixels_done_in = done;
      column_in      = column;
      pad_left_in    = pad;
      phase_in       = phase;
      held_blue_in   = blue;
      held_green_in  = green;

      stage_valid_in      = 1'b0;
      stage_in.is_pixel   = 1'b0;
      stage_in.count      = EMIT_ONE;
      stage_in.data_byte  = req_tdata;
      stage_in.green      = green;
      stage_in.blue       = blue;

      if (32'(pos) < header_len_ff) begin
         stage_valid_in = 1'b1;
      end else if (done < pixel_total_ff) begin
         if (pad != 2'd0) begin
            stage_valid_in = 1'b1;
            pad_left_in    = pad - 2'd1;
         end else if (phase == PHASE_BLUE) begin
            held_blue_in = req_tdata;
            phase_in     = PHASE_GREEN;
         end else if (phase == PHASE_GREEN) begin
            held_green_in = req_tdata;
            phase_in      = PHASE_RED;
         end else begin
            stage_valid_in    = 1'b1;
            stage_in.is_pixel = 1'b1;
            stage_in.count    = EMIT_THREE;
            phase_in          = PHASE_BLUE;
            pixels_done_in    = done_next;
            column_in         = column_next;
            if (column_next >= image_width_ff) begin
               column_in = '0;
               // With three bytes per pixel, (4 - 3*width mod 4) mod 4 is width mod 4.
               if (done_next < pixel_total_ff) begin
                  pad_left_in = image_width_ff[1:0];
               end
            end
         end
      end else if (32'(pos) < total_len_ff) begin
         stage_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         pixels_done_ff <= '0;
         column_ff      <= '0;
         pad_left_ff    <= '0;
         phase_ff       <= PHASE_BLUE;
         held_blue_ff   <= '0;
         held_green_ff  <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_fire & stage_valid_in;
         if (req_fire) begin
            position_ff    <= position_in;
            pixels_done_ff <= pixels_done_in;
            column_ff      <= column_in;
            pad_left_ff    <= pad_left_in;
            phase_ff       <= phase_in;
            held_blue_ff   <= held_blue_in;
            held_green_ff  <= held_green_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff <= stage_in;
      end
   end

   // Conversion stage: each product of a byte and a Q1.8 weight is truncated before the sum.
   logic [16:0] red_product;
   logic [16:0] green_product;
   logic [16:0] blue_product;
   logic [9:0]  gray_sum;
   logic        is_white;
   run_type     run_in;

   assign red_product   = stage_ff.data_byte * coef_red_ff;
   assign green_product = stage_ff.green * coef_green_ff;
   assign blue_product  = stage_ff.blue * coef_blue_ff;
   assign gray_sum      = {1'b0, red_product[16:8]} + {1'b0, green_product[16:8]}
                          + {1'b0, blue_product[16:8]};
   assign is_white      = (stage_ff.data_byte == ByteMax) && (stage_ff.green == ByteMax)
                          && (stage_ff.blue == ByteMax);

   always_comb begin
      run_in.count = stage_ff.count;
      if (!stage_ff.is_pixel) begin
         run_in.value = stage_ff.data_byte;
      end else if (is_white) begin
         run_in.value = ByteMax;
      end else begin
         run_in.value = gray_sum[7:0];
      end
   end

   // Run queue: each entry is sent count times, tlast on the final copy.
   run_type                 queue_ff [QueueDepth];
   logic [QueuePtrBits-1:0] write_ptr_ff;
   logic [QueuePtrBits-1:0] read_ptr_ff;
   logic [1:0]              copy_ff;
   run_type                 head;
   logic                    rsp_fire;
   logic                    pop;

   assign head       = queue_ff[read_ptr_ff];
   assign rsp_tvalid = (queue_count_ff != '0);
   assign rsp_tdata  = head.value;
   assign rsp_tlast  = (copy_ff == (head.count - 2'd1));
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign pop        = rsp_fire & rsp_tlast;

   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         queue_ff[write_ptr_ff] <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff   <= '0;
         read_ptr_ff    <= '0;
         queue_count_ff <= '0;
         copy_ff        <= '0;
      end else begin
         if (stage_valid_ff) begin
            write_ptr_ff <= write_ptr_ff + 1'b1;
         end
         if (pop) begin
            read_ptr_ff <= read_ptr_ff + 1'b1;
            copy_ff     <= '0;
         end else if (rsp_fire) begin
            copy_ff <= copy_ff + 2'd1;
         end
         case ({stage_valid_ff, pop})
            2'b10:   queue_count_ff <= queue_count_ff + 1'b1;
            2'b01:   queue_count_ff <= queue_count_ff - 1'b1;
            default: queue_count_ff <= queue_count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire
